// ----- rtl/prf_pkg.sv -----
// Shared types, constants and codes for the polygon ring point filter.
package prf_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int MIN_POLY     = 3;
    localparam int VTX_W        = 64;
    localparam int COORD_W      = 32;
    localparam int TRIG_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = DIFF_W + TRIG_W;
    localparam int CROSS_W      = 2 * DIFF_W;

    localparam logic [CFG_IDX_W-1:0] CFG_POSE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 2'd3;

    localparam logic [TRIG_W-1:0] COS_RESET = 16'h7FFF;

    typedef enum logic [1:0] {
        OP_LOAD_OUTER = 2'd0,
        OP_LOAD_INNER = 2'd1,
        OP_TEST       = 2'd2,
        OP_CLEAR      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // vehicle-frame vertex handed from the transform to the edge test
    typedef struct packed {
        logic                      valid;
        logic                      first;
        logic signed [COORD_W-1:0] lx;
        logic signed [COORD_W-1:0] ly;
    } t_vtx;

endpackage

// ----- rtl/prf_if.sv -----
// Point input and result output channel interfaces.
interface prf_in_if;
    import prf_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic [COORD_W-1:0]  point_z;
    modport source (output valid, op, coord_x, coord_y, point_z, input ready);
    modport sink   (input valid, op, coord_x, coord_y, point_z, output ready);
endinterface

interface prf_out_if;
    import prf_pkg::*;
    logic                valid;
    logic                ready;
    logic [COORD_W-1:0]  out_x;
    logic [COORD_W-1:0]  out_y;
    logic [COORD_W-1:0]  out_z;
    logic                keep;
    logic                inside_outer;
    logic                inside_inner;
    modport source (output valid, out_x, out_y, out_z, keep, inside_outer, inside_inner,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, keep, inside_outer, inside_inner,
                    output ready);
endinterface

// ----- rtl/prf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module prf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/prf_xform.sv -----
// Map-to-vehicle frame transform pipeline: offset, rotate, round and saturate.
module prf_xform (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_first,
    input  logic [prf_pkg::VTX_W-1:0]         i_vtx,
    input  logic [prf_pkg::COORD_W-1:0]       i_pose_x,
    input  logic [prf_pkg::COORD_W-1:0]       i_pose_y,
    input  logic [prf_pkg::TRIG_W-1:0]        i_cos,
    input  logic [prf_pkg::TRIG_W-1:0]        i_sin,
    output prf_pkg::t_vtx                     o_vtx,
    output logic                              o_busy
);
    import prf_pkg::*;

    localparam int SUM_W = PROD_W + 2;
    localparam int SHR_W = SUM_W - 15;

    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] t;
        logic signed [SHR_W-1:0] q;
        t = v + SUM_W'(16384);
        q = SHR_W'(t >>> 15);
        if (q > SHR_W'(32'sh7FFF_FFFF)) begin
            round_sat = 32'sh7FFF_FFFF;
        end else if (q < -(SHR_W'(33'sh0_8000_0000))) begin
            round_sat = 32'sh8000_0000;
        end else begin
            round_sat = q[COORD_W-1:0];
        end
    endfunction

    logic                      r_v2, r_f2, r_v3, r_f3;
    logic signed [DIFF_W-1:0]  r_dx, r_dy;
    logic signed [PROD_W-1:0]  r_dxc, r_dys, r_dxs, r_dyc;
    t_vtx                      r_out;
    logic signed [DIFF_W-1:0]  n_dx, n_dy;
    logic signed [SUM_W-1:0]   n_sx, n_sy;

    always_comb begin
        n_dx = signed'({i_vtx[COORD_W-1], i_vtx[COORD_W-1:0]})
             - signed'({i_pose_x[COORD_W-1], i_pose_x});
        n_dy = signed'({i_vtx[VTX_W-1], i_vtx[VTX_W-1:COORD_W]})
             - signed'({i_pose_y[COORD_W-1], i_pose_y});
        n_sx = SUM_W'(r_dxc) + SUM_W'(r_dys);
        n_sy = SUM_W'(r_dyc) - SUM_W'(r_dxs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_v2        <= i_valid;
            r_v3        <= r_v2;
            r_out.valid <= r_v3;
        end
        r_f2     <= i_first;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_f3     <= r_f2;
        r_dxc    <= r_dx * signed'(i_cos);
        r_dys    <= r_dy * signed'(i_sin);
        r_dxs    <= r_dx * signed'(i_sin);
        r_dyc    <= r_dy * signed'(i_cos);
        r_out.first <= r_f3;
        r_out.lx    <= round_sat(n_sx);
        r_out.ly    <= round_sat(n_sy);
    end

    assign o_vtx  = r_out;
    assign o_busy = r_v2 | r_v3;
endmodule

// ----- rtl/prf_edge.sv -----
// Even-odd crossing test over consecutive vehicle-frame vertices.
module prf_edge (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clr,
    input  prf_pkg::t_vtx                i_vtx,
    input  logic [prf_pkg::COORD_W-1:0]  i_px,
    input  logic [prf_pkg::COORD_W-1:0]  i_py,
    output logic                         o_parity,
    output logic                         o_busy
);
    import prf_pkg::*;

    logic signed [COORD_W-1:0] r_xj, r_yj;
    logic                      r_v5, r_v6, r_par;
    logic signed [DIFF_W-1:0]  r_a, r_d, r_b, r_e;
    logic signed [CROSS_W-1:0] r_lhs, r_rhs;
    logic                      n_cross;
    logic signed [DIFF_W-1:0]  n_a, n_d, n_b, n_e, n_dd;
    logic signed [COORD_W-1:0] px, py;

    always_comb begin
        px      = signed'(i_px);
        py      = signed'(i_py);
        n_cross = (i_vtx.ly > py) != (r_yj > py);
        n_dd    = DIFF_W'(r_yj) - DIFF_W'(i_vtx.ly);
        n_a     = DIFF_W'(px) - DIFF_W'(i_vtx.lx);
        n_b     = DIFF_W'(r_xj) - DIFF_W'(i_vtx.lx);
        if (n_dd > 0) begin
            n_d = n_dd;
            n_e = DIFF_W'(py) - DIFF_W'(i_vtx.ly);
        end else begin
            n_d = -n_dd;
            n_e = DIFF_W'(i_vtx.ly) - DIFF_W'(py);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_par <= 1'b0;
        end else begin
            r_v5 <= i_vtx.valid & ~i_vtx.first & n_cross;
            r_v6 <= r_v5;
            if (i_clr) begin
                r_par <= 1'b0;
            end else if (r_v6 && (r_lhs < r_rhs)) begin
                r_par <= ~r_par;
            end
        end
        // hold the previous vertex to close each edge
        if (i_vtx.valid) begin
            r_xj <= i_vtx.lx;
            r_yj <= i_vtx.ly;
        end
        r_a   <= n_a;
        r_d   <= n_d;
        r_b   <= n_b;
        r_e   <= n_e;
        r_lhs <= r_a * r_d;
        r_rhs <= r_b * r_e;
    end

    assign o_parity = r_par;
    assign o_busy   = r_v5 | r_v6;
endmodule

// ----- rtl/polygon_ring_point_filter.sv -----
// Top level: vertex stores, pass sequencer, configuration and result register.
//
//  channel  | dir | payload                                       | accepted when
//  i_pt     | in  | op, coord_x, coord_y, point_z                 | valid & ready
//  o_res    | out | out_x, out_y, out_z, keep, inside_outer/inner | valid & ready
//  cfg      | in  | i_cfg_idx, i_cfg_data                         | i_cfg_we
//
// Loads and clears complete on acceptance. A test reads the outer then the inner store, one
// vertex per cycle through the read port, starting each ring with its last vertex; a
// polygon under three vertices is not read and counts as outside. Reset clears counts,
// pose and the result valid flag; store contents and result data stay unknown. A result
// waiting on a stalled output lets loads and clears through; the next test holds at its
// end.
module polygon_ring_point_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    prf_in_if.sink                           i_pt,
    prf_out_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [prf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [prf_pkg::COORD_W-1:0]      i_cfg_data
);
    import prf_pkg::*;

    t_state               r_state, n_state;
    logic                 r_sel, n_sel;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [CNT_W-1:0]     r_ocnt, r_icnt;
    logic [COORD_W-1:0]   r_px, r_py, r_pz;
    logic                 r_io, r_ii, n_io, n_ii;
    logic [COORD_W-1:0]   r_pose_x, r_pose_y;
    logic [TRIG_W-1:0]    r_cos, r_sin;
    logic                 r_oval;
    logic [COORD_W-1:0]   r_ox, r_oy, r_oz;
    logic                 r_ok, r_oio, r_oii;
    logic                 r_v1, r_f1;

    logic                 acc, issue, clr, load_out, pipe_busy, xf_busy, ed_busy, parity;
    logic [CNT_W-1:0]     n_cnt;
    logic [ADDR_W-1:0]    raddr;
    logic                 we_o, we_i;
    logic [VTX_W-1:0]     wdata, rd_o, rd_i;
    t_vtx                 vtx;

    assign acc   = i_pt.valid & i_pt.ready;
    assign wdata = {i_pt.coord_y, i_pt.coord_x};
    assign we_o  = acc && (t_op'(i_pt.op) == OP_LOAD_OUTER)
                   && (r_ocnt < CNT_W'(MAX_VERTICES));
    assign we_i  = acc && (t_op'(i_pt.op) == OP_LOAD_INNER)
                   && (r_icnt < CNT_W'(MAX_VERTICES));
    assign n_cnt = r_sel ? r_icnt : r_ocnt;
    // first read closes the ring with the last vertex
    assign raddr = (r_k == '0) ? ADDR_W'(n_cnt - CNT_W'(1)) : ADDR_W'(r_k - CNT_W'(1));

    prf_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_outer (
        .i_clk(i_clk), .i_we(we_o), .i_waddr(r_ocnt[ADDR_W-1:0]), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd_o)
    );

    prf_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_inner (
        .i_clk(i_clk), .i_we(we_i), .i_waddr(r_icnt[ADDR_W-1:0]), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd_i)
    );

    prf_xform u_xform (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v1), .i_first(r_f1),
        .i_vtx(r_sel ? rd_i : rd_o), .i_pose_x(r_pose_x), .i_pose_y(r_pose_y),
        .i_cos(r_cos), .i_sin(r_sin), .o_vtx(vtx), .o_busy(xf_busy)
    );

    prf_edge u_edge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clr(clr), .i_vtx(vtx),
        .i_px(r_px), .i_py(r_py), .o_parity(parity), .o_busy(ed_busy)
    );

    assign pipe_busy = r_v1 | xf_busy | vtx.valid | ed_busy;

    always_comb begin
        n_state  = r_state;
        n_sel    = r_sel;
        n_k      = r_k;
        n_io     = r_io;
        n_ii     = r_ii;
        issue    = 1'b0;
        clr      = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && (t_op'(i_pt.op) == OP_TEST)) begin
                    n_sel   = 1'b0;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                clr = 1'b1;
                n_k = '0;
                n_state = (n_cnt >= CNT_W'(MIN_POLY)) ? ST_RUN : ST_DRAIN;
            end
            ST_RUN: begin
                issue = 1'b1;
                n_k   = r_k + CNT_W'(1);
                if (r_k == n_cnt) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    if (r_sel) begin
                        n_ii    = parity;
                        n_state = ST_DONE;
                    end else begin
                        n_io    = parity;
                        n_sel   = 1'b1;
                        n_state = ST_START;
                    end
                end
            end
            ST_DONE: begin
                // hold until the result register frees up
                if (!r_oval || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sel    <= 1'b0;
            r_k      <= '0;
            r_ocnt   <= '0;
            r_icnt   <= '0;
            r_pose_x <= '0;
            r_pose_y <= '0;
            r_cos    <= COS_RESET;
            r_sin    <= '0;
            r_oval   <= 1'b0;
            r_v1     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_k     <= n_k;
            r_v1    <= issue;
            if (we_o) begin
                r_ocnt <= r_ocnt + CNT_W'(1);
            end
            if (we_i) begin
                r_icnt <= r_icnt + CNT_W'(1);
            end
            if (acc && (t_op'(i_pt.op) == OP_CLEAR)) begin
                r_ocnt <= '0;
                r_icnt <= '0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POSE_X: r_pose_x <= i_cfg_data;
                    CFG_POSE_Y: r_pose_y <= i_cfg_data;
                    CFG_COS:    r_cos    <= i_cfg_data[TRIG_W-1:0];
                    CFG_SIN:    r_sin    <= i_cfg_data[TRIG_W-1:0];
                    default:    ;
                endcase
            end
            if (load_out) begin
                r_oval <= 1'b1;
            end else if (o_res.ready) begin
                r_oval <= 1'b0;
            end
        end
        r_f1 <= (r_k == '0);
        r_io <= n_io;
        r_ii <= n_ii;
        if (acc) begin
            r_px <= i_pt.coord_x;
            r_py <= i_pt.coord_y;
            r_pz <= i_pt.point_z;
        end
        if (load_out) begin
            r_ox  <= r_px;
            r_oy  <= r_py;
            r_oz  <= r_pz;
            r_oio <= r_io;
            r_oii <= n_ii;
            r_ok  <= n_ii & ~r_io;
        end
    end

    assign i_pt.ready         = (r_state == ST_IDLE);
    assign o_res.valid        = r_oval;
    assign o_res.out_x        = r_ox;
    assign o_res.out_y        = r_oy;
    assign o_res.out_z        = r_oz;
    assign o_res.keep         = r_ok;
    assign o_res.inside_outer = r_oio;
    assign o_res.inside_inner = r_oii;
endmodule
